// ===== design/assert_macros.svh =====
// assertion macros shared by the orbit camera update block
// used by files that check their own control logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/ocu_pkg.sv =====
// orbit camera update: shared constants, command and sine unit types
// no dependencies
package ocu_pkg;
   localparam int ANGLE_BITS_DEF = 20;
   localparam int COORD_BITS_DEF = 32;
   localparam int MAX_SCROLL_DEF = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int DELTA_W = 16;
   localparam int STEPS_W = 5;
   localparam int SCROLL_W = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HOME_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_YAW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_PITCH = 2'd2;

   localparam logic [31:0] HOME_DISTANCE_RST = 32'd327680;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;
   localparam logic [22:0] RAD01_Q32 = 23'd6835653;
   localparam longint RAD0001_Q32 = 68357;
   localparam logic [30:0] GROW_Q30 = 31'd1181116006;
   localparam logic [30:0] SHRINK_Q30 = 31'd976128931;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] PAN_RECIP = 32'd2748779069;
   localparam int PAN_SHIFT = 38;
   localparam logic [6:0] PAN_DIV = 7'd100;
   localparam logic [5:0] PAN_BIAS = 6'd50;

   localparam logic [3:0] SC_SIN_LAST = 4'd4;
   localparam logic [3:0] SC_COS_FIRST = 4'd5;
   localparam logic [3:0] SC_COS_LAST = 4'd10;

   typedef enum logic [1:0] {
      KIND_IDLE = 2'd0,
      KIND_HOME = 2'd1,
      KIND_ROT  = 2'd2,
      KIND_PAN  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic scroll_grow;
      logic [SCROLL_W-1:0] scroll_cnt;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic signed [31:0] sin_val;
      logic signed [31:0] cos_val;
   } sc_rsp_type;

   // floor(2^32 / den) of the series terms, sine terms first
   function automatic logic [31:0] sc_recip(input logic [3:0] k);
      case (k)
         4'd0: sc_recip = 32'd39045157;
         4'd1: sc_recip = 32'd59652323;
         4'd2: sc_recip = 32'd102261126;
         4'd3: sc_recip = 32'd214748364;
         4'd4: sc_recip = 32'd715827882;
         4'd5: sc_recip = 32'd32537631;
         4'd6: sc_recip = 32'd47721858;
         4'd7: sc_recip = 32'd76695844;
         4'd8: sc_recip = 32'd143165576;
         4'd9: sc_recip = 32'd357913941;
         4'd10: sc_recip = 32'd2147483648;
         default: sc_recip = 32'd0;
      endcase
   endfunction

   function automatic logic [7:0] sc_den(input logic [3:0] k);
      case (k)
         4'd0: sc_den = 8'd110;
         4'd1: sc_den = 8'd72;
         4'd2: sc_den = 8'd42;
         4'd3: sc_den = 8'd20;
         4'd4: sc_den = 8'd6;
         4'd5: sc_den = 8'd132;
         4'd6: sc_den = 8'd90;
         4'd7: sc_den = 8'd56;
         4'd8: sc_den = 8'd30;
         4'd9: sc_den = 8'd12;
         4'd10: sc_den = 8'd2;
         default: sc_den = 8'd1;
      endcase
   endfunction
endpackage

// ===== design/ocu_ifc.sv =====
// orbit camera update: request, response and register write channels
// depends on ocu_pkg
interface ocu_req_if;
   import ocu_pkg::*;
   logic valid;
   logic ready;
   logic go_home;
   logic left_button;
   logic shift_held;
   logic signed [DELTA_W-1:0] delta_x;
   logic signed [DELTA_W-1:0] delta_y;
   logic signed [STEPS_W-1:0] scroll_steps;
   modport source(output valid, go_home, left_button, shift_held, delta_x, delta_y,
                  scroll_steps, input ready);
   modport sink(input valid, go_home, left_button, shift_held, delta_x, delta_y,
                scroll_steps, output ready);
endinterface

interface ocu_rsp_if #(parameter int COORD_BITS = ocu_pkg::COORD_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] eye_x;
   logic signed [COORD_BITS-1:0] eye_y;
   logic signed [COORD_BITS-1:0] eye_z;
   logic signed [COORD_BITS-1:0] look_x;
   logic signed [COORD_BITS-1:0] look_y;
   logic signed [COORD_BITS-1:0] look_z;
   modport source(output valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, input ready);
   modport sink(input valid, eye_x, eye_y, eye_z, look_x, look_y, look_z, output ready);
endinterface

interface ocu_csr_if;
   import ocu_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== design/ocu_front.sv =====
// orbit camera update front: takes request words, classifies them, queues commands
// depends on ocu_pkg, ocu_ifc, assert_macros.svh
`include "assert_macros.svh"
module ocu_front #(
   parameter int MAX_SCROLL = ocu_pkg::MAX_SCROLL_DEF
) (
   input  logic clock,
   input  logic reset,
   ocu_req_if.sink req_ch,
   input  logic pop,
   output ocu_pkg::cmd_type cmd,
   output logic cmd_valid
);
   import ocu_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type q_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type new_cmd;
   logic push;
   logic signed [6:0] steps, steps_sat, max_s;

   always_comb begin
      max_s = 7'(MAX_SCROLL);
      steps = 7'(req_ch.scroll_steps);
      if (steps > max_s) begin
         steps_sat = max_s;
      end else if (steps < -max_s) begin
         steps_sat = -max_s;
      end else begin
         steps_sat = steps;
      end
      new_cmd.delta_x = req_ch.delta_x;
      new_cmd.delta_y = req_ch.delta_y;
      new_cmd.scroll_grow = steps_sat[6];
      new_cmd.scroll_cnt = steps_sat[6] ? SCROLL_W'(-steps_sat) : SCROLL_W'(steps_sat);
      if (req_ch.go_home) begin
         new_cmd.kind = KIND_HOME;
         new_cmd.scroll_cnt = '0;
      end else if (!req_ch.left_button) begin
         new_cmd.kind = KIND_IDLE;
      end else if (req_ch.shift_held) begin
         new_cmd.kind = KIND_PAN;
      end else begin
         new_cmd.kind = KIND_ROT;
      end
   end

   assign req_ch.ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push = req_ch.valid && req_ch.ready;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, cnt_ff <= CNT_W'(QUEUE_DEPTH), "queue overfull")
   `ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, cnt_ff != '0, "pop from empty queue")
endmodule

// ===== design/ocu_sincos.sv =====
// orbit camera update: iterative sine and cosine in Q30 over a shared multiplier
// depends on ocu_pkg, assert_macros.svh
`include "assert_macros.svh"
module ocu_sincos #(
   parameter int ANGLE_BITS = ocu_pkg::ANGLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [ANGLE_BITS-1:0] angle,
   output ocu_pkg::sc_rsp_type rsp
);
   import ocu_pkg::*;

   typedef enum logic [7:0] {
      SC_IDLE = 8'b0000_0001,
      SC_X    = 8'b0000_0010,
      SC_X2   = 8'b0000_0100,
      SC_Q    = 8'b0000_1000,
      SC_C    = 8'b0001_0000,
      SC_T    = 8'b0010_0000,
      SC_S    = 8'b0100_0000,
      SC_FIN  = 8'b1000_0000
   } sc_state_type;

   sc_state_type state_ff, state_in;
   logic [2:0] oct_ff, oct_in;
   logic [29:0] r_ff, r_in, x_ff, x_in, x2_ff, x2_in, q_ff, q_in;
   logic [30:0] t_ff, t_in, s_ff, s_in;
   logic [3:0] k_ff, k_in;
   sc_rsp_type rsp_ff, rsp_in;
   logic [31:0] a32, ma, mb;
   logic [63:0] prod;
   logic [37:0] qd;
   logic [29:0] rem;
   logic [30:0] sv, cv;
   logic swap;

   assign prod = 64'(ma) * 64'(mb);
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      oct_in = oct_ff;
      r_in = r_ff;
      x_in = x_ff;
      x2_in = x2_ff;
      q_in = q_ff;
      t_in = t_ff;
      s_in = s_ff;
      k_in = k_ff;
      rsp_in = rsp_ff;
      rsp_in.done = 1'b0;
      ma = '0;
      mb = '0;
      a32 = 32'(angle) << (32 - ANGLE_BITS);
      qd = 38'(q_ff) * 38'(sc_den(k_ff));
      rem = x2_ff - 30'(qd);
      swap = oct_ff[0] ^ oct_ff[1];
      sv = swap ? t_ff : s_ff;
      cv = swap ? s_ff : t_ff;
      case (state_ff)
         SC_IDLE: begin
            if (start) begin
               oct_in = a32[31:29];
               r_in = a32[29] ? 30'h2000_0000 - 30'(a32[28:0]) : 30'(a32[28:0]);
               state_in = SC_X;
            end
         end
         SC_X: begin
            ma = 32'(r_ff);
            mb = PI_Q30;
            x_in = 30'((prod + 64'h4000_0000) >> 31);
            state_in = SC_X2;
         end
         SC_X2: begin
            ma = 32'(x_ff);
            mb = 32'(x_ff);
            x2_in = 30'((prod + 64'h2000_0000) >> 30);
            t_in = Q30_ONE;
            k_in = '0;
            state_in = SC_Q;
         end
         SC_Q: begin
            ma = 32'(x2_ff);
            mb = sc_recip(k_ff);
            q_in = 30'(prod >> 32);
            state_in = SC_C;
         end
         SC_C: begin
            if (rem >= 30'(sc_den(k_ff))) begin
               q_in = q_ff + 1'b1;
            end
            state_in = SC_T;
         end
         SC_T: begin
            ma = 32'(q_ff);
            mb = 32'(t_ff);
            t_in = Q30_ONE - 31'((prod + 64'h2000_0000) >> 30);
            if (k_ff == SC_SIN_LAST) begin
               state_in = SC_S;
            end else if (k_ff == SC_COS_LAST) begin
               state_in = SC_FIN;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = SC_Q;
            end
         end
         SC_S: begin
            ma = 32'(x_ff);
            mb = 32'(t_ff);
            s_in = 31'((prod + 64'h2000_0000) >> 30);
            t_in = Q30_ONE;
            k_in = SC_COS_FIRST;
            state_in = SC_Q;
         end
         SC_FIN: begin
            rsp_in.done = 1'b1;
            rsp_in.sin_val = oct_ff[2] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
            rsp_in.cos_val = (oct_ff[2] ^ oct_ff[1]) ? -$signed({1'b0, cv})
                                                    : $signed({1'b0, cv});
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
   end

   always_ff @(posedge clock) begin
      oct_ff <= oct_in;
      r_ff <= r_in;
      x_ff <= x_in;
      x2_ff <= x2_in;
      q_ff <= q_in;
      t_ff <= t_in;
      s_ff <= s_in;
      k_ff <= k_in;
      rsp_ff.sin_val <= rsp_in.sin_val;
      rsp_ff.cos_val <= rsp_in.cos_val;
   end

   `ASSERT_IMPL(a_start_idle, clock, reset, start, state_ff == SC_IDLE, "start while busy")
endmodule

// ===== design/ocu_exec.sv =====
// orbit camera update back end: camera state, registers, scroll, pan and eye math
// depends on ocu_pkg, ocu_ifc, ocu_sincos results, assert_macros.svh
`include "assert_macros.svh"
module ocu_exec #(
   parameter int ANGLE_BITS = ocu_pkg::ANGLE_BITS_DEF,
   parameter int COORD_BITS = ocu_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  ocu_pkg::cmd_type cmd,
   input  logic cmd_valid,
   output logic pop,
   ocu_csr_if.sink csr_ch,
   ocu_rsp_if.source rsp_ch,
   output logic sc_start,
   output logic [ANGLE_BITS-1:0] sc_angle,
   input  ocu_pkg::sc_rsp_type sc_rsp
);
   import ocu_pkg::*;

   localparam int AB = ANGLE_BITS;
   localparam int CB = COORD_BITS;
   localparam int SW = ((CB > 40) ? CB : 40) + 2;
   localparam int SH = 32 - AB;
   localparam logic [39:0] HALF = (40'd1 << SH) >> 1;
   localparam longint MARGIN = ((RAD0001_Q32 << AB) + (64'sd1 <<< 31)) >>> 32;
   localparam logic signed [AB:0] LIM = (AB + 1)'((64'sd1 <<< (AB - 2)) - MARGIN);

   typedef enum logic [9:0] {
      EX_IDLE = 10'b00_0000_0001,
      EX_UPD  = 10'b00_0000_0010,
      EX_PANC = 10'b00_0000_0100,
      EX_SCRL = 10'b00_0000_1000,
      EX_SCY  = 10'b00_0001_0000,
      EX_SCP  = 10'b00_0010_0000,
      EX_PAN  = 10'b00_0100_0000,
      EX_OFF  = 10'b00_1000_0000,
      EX_EYE  = 10'b01_0000_0000,
      EX_DONE = 10'b10_0000_0000
   } ex_state_type;

   ex_state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [31:0] hdist_ff, hdist_in;
   logic [AB-1:0] hyaw_ff, hyaw_in;
   logic [AB-2:0] hpitch_ff, hpitch_in;
   logic [AB-1:0] yaw_ff, yaw_in;
   logic signed [AB-1:0] pitch_ff, pitch_in;
   logic [31:0] dist_ff, dist_in;
   logic signed [CB-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [CB-1:0] ex_ff, ex_in, ey_ff, ey_in, ez_ff, ez_in;
   logic signed [CB-1:0] oex_ff, oex_in, oey_ff, oey_in, oez_ff, oez_in;
   logic signed [CB-1:0] olx_ff, olx_in, oly_ff, oly_in, olz_ff, olz_in;
   logic ovalid_ff, ovalid_in;
   logic [SCROLL_W-1:0] cnt_ff, cnt_in;
   logic [2:0] ps_ff, ps_in;
   logic [25:0] pqx_ff, pqx_in, pqy_ff, pqy_in;
   logic signed [26:0] pan_a_ff, pan_a_in, pan_b_ff, pan_b_in;
   logic signed [31:0] sy_ff, sy_in, cy_s_ff, cy_s_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [39:0] t1_ff, t1_in, acc_ff, acc_in;

   logic signed [35:0] a_sel;
   logic signed [32:0] b_sel;
   logic [35:0] ma;
   logic [32:0] mb;
   logic [68:0] prod;
   logic [38:0] rnd;
   logic signed [39:0] mres;

   logic [16:0] mdx, mdy;
   logic [39:0] stx, sty;
   logic signed [41:0] psum;
   logic [41:0] pmag;
   logic signed [AB:0] prem, prot, phome;
   logic [32:0] numx, numy;
   logic [39:0] qdx, qdy;
   logic [25:0] pnx, pny;

   function automatic logic signed [AB:0] clamp_p(input logic signed [AB:0] v);
      if (v > LIM) begin
         clamp_p = LIM;
      end else if (v < -LIM) begin
         clamp_p = -LIM;
      end else begin
         clamp_p = v;
      end
   endfunction

   function automatic logic signed [CB-1:0] sat_c(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      hi = $signed({{(SW - CB + 1){1'b0}}, {(CB - 1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         sat_c = hi[CB-1:0];
      end else if (v < lo) begin
         sat_c = lo[CB-1:0];
      end else begin
         sat_c = v[CB-1:0];
      end
   endfunction

   // shared signed q30 multiply, magnitudes rounded half up
   always_comb begin
      ma = a_sel[35] ? 36'(-a_sel) : 36'(a_sel);
      mb = b_sel[32] ? 33'(-b_sel) : 33'(b_sel);
      prod = 69'(ma) * 69'(mb);
      rnd = 39'((prod + 69'(32'h2000_0000)) >> 30);
      mres = (a_sel[35] ^ b_sel[32]) ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
   end

   // rotation and pan step arithmetic
   always_comb begin
      mdx = cmd_ff.delta_x[DELTA_W-1] ? 17'(-cmd_ff.delta_x) : 17'(cmd_ff.delta_x);
      mdy = cmd_ff.delta_y[DELTA_W-1] ? 17'(-cmd_ff.delta_y) : 17'(cmd_ff.delta_y);
      stx = ((40'(mdx) * 40'(RAD01_Q32)) + HALF) >> SH;
      sty = ((40'(mdy) * 40'(RAD01_Q32)) + HALF) >> SH;
      psum = 42'(pitch_ff) + (cmd_ff.delta_y[DELTA_W-1] ? -$signed({2'b0, sty})
                                                         : $signed({2'b0, sty}));
      pmag = psum[41] ? 42'(-psum) : 42'(psum);
      prem = psum[41] ? -$signed({1'b0, pmag[AB-1:0]}) : $signed({1'b0, pmag[AB-1:0]});
      prot = clamp_p(prem);
      phome = clamp_p((AB + 1)'($signed(hpitch_ff)));
      numx = {mdx, 16'b0} + 33'(PAN_BIAS);
      numy = {mdy, 16'b0} + 33'(PAN_BIAS);
      qdx = 40'(pqx_ff) * 40'(PAN_DIV);
      qdy = 40'(pqy_ff) * 40'(PAN_DIV);
      pnx = ((40'(numx) - qdx) >= 40'(PAN_DIV)) ? pqx_ff + 1'b1 : pqx_ff;
      pny = ((40'(numy) - qdy) >= 40'(PAN_DIV)) ? pqy_ff + 1'b1 : pqy_ff;
   end

   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = ovalid_ff;
   assign rsp_ch.eye_x = oex_ff;
   assign rsp_ch.eye_y = oey_ff;
   assign rsp_ch.eye_z = oez_ff;
   assign rsp_ch.look_x = olx_ff;
   assign rsp_ch.look_y = oly_ff;
   assign rsp_ch.look_z = olz_ff;
   assign pop = cmd_valid && (state_ff == EX_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      hdist_in = hdist_ff;
      hyaw_in = hyaw_ff;
      hpitch_in = hpitch_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      dist_in = dist_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      ez_in = ez_ff;
      oex_in = oex_ff;
      oey_in = oey_ff;
      oez_in = oez_ff;
      olx_in = olx_ff;
      oly_in = oly_ff;
      olz_in = olz_ff;
      ovalid_in = ovalid_ff && !rsp_ch.ready;
      cnt_in = cnt_ff;
      ps_in = ps_ff;
      pqx_in = pqx_ff;
      pqy_in = pqy_ff;
      pan_a_in = pan_a_ff;
      pan_b_in = pan_b_ff;
      sy_in = sy_ff;
      cy_s_in = cy_s_ff;
      sp_in = sp_ff;
      cp_in = cp_ff;
      t1_in = t1_ff;
      acc_in = acc_ff;
      sc_start = 1'b0;
      sc_angle = yaw_ff;
      a_sel = 36'($signed({1'b0, dist_ff}));
      b_sel = 33'($signed({1'b0, SHRINK_Q30}));

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_HOME_DISTANCE: hdist_in = csr_ch.data[31:0];
            CSR_HOME_YAW: hyaw_in = csr_ch.data[AB-1:0];
            CSR_HOME_PITCH: hpitch_in = csr_ch.data[AB-2:0];
            default: ;
         endcase
      end

      case (state_ff)
         EX_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               state_in = EX_UPD;
            end
         end
         EX_UPD: begin
            cnt_in = cmd_ff.scroll_cnt;
            pqx_in = 26'((64'(numx) * 64'(PAN_RECIP)) >> PAN_SHIFT);
            pqy_in = 26'((64'(numy) * 64'(PAN_RECIP)) >> PAN_SHIFT);
            case (cmd_ff.kind)
               KIND_HOME: begin
                  yaw_in = hyaw_ff;
                  pitch_in = prot[AB-1:0];
                  pitch_in = phome[AB-1:0];
                  dist_in = (hdist_ff == '0) ? 32'd1 : hdist_ff;
                  cx_in = '0;
                  cy_in = '0;
                  cz_in = '0;
               end
               KIND_ROT: begin
                  yaw_in = cmd_ff.delta_x[DELTA_W-1] ? yaw_ff + stx[AB-1:0]
                                                     : yaw_ff - stx[AB-1:0];
                  pitch_in = prot[AB-1:0];
               end
               default: ;
            endcase
            state_in = EX_PANC;
         end
         EX_PANC: begin
            pan_a_in = cmd_ff.delta_x[DELTA_W-1] ? $signed({1'b0, pnx})
                                                 : -$signed({1'b0, pnx});
            pan_b_in = cmd_ff.delta_y[DELTA_W-1] ? -$signed({1'b0, pny})
                                                 : $signed({1'b0, pny});
            state_in = EX_SCRL;
         end
         EX_SCRL: begin
            b_sel = cmd_ff.scroll_grow ? 33'($signed({1'b0, GROW_Q30}))
                                       : 33'($signed({1'b0, SHRINK_Q30}));
            if (cnt_ff == '0) begin
               sc_start = 1'b1;
               sc_angle = yaw_ff;
               state_in = EX_SCY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (mres == '0) begin
                  dist_in = 32'd1;
               end else if (mres > 40'sh0_FFFF_FFFF) begin
                  dist_in = 32'hFFFF_FFFF;
               end else begin
                  dist_in = mres[31:0];
               end
            end
         end
         EX_SCY: begin
            if (sc_rsp.done) begin
               sy_in = sc_rsp.sin_val;
               cy_s_in = sc_rsp.cos_val;
               sc_start = 1'b1;
               sc_angle = pitch_ff;
               state_in = EX_SCP;
            end
         end
         EX_SCP: begin
            if (sc_rsp.done) begin
               sp_in = sc_rsp.sin_val;
               cp_in = sc_rsp.cos_val;
               ps_in = '0;
               state_in = (cmd_ff.kind == KIND_PAN) ? EX_PAN : EX_OFF;
            end
         end
         EX_PAN: begin
            ps_in = ps_ff + 1'b1;
            case (ps_ff)
               3'd0: begin
                  a_sel = 36'(sp_ff);
                  b_sel = 33'(pan_b_ff);
                  t1_in = mres;
               end
               3'd1: begin
                  a_sel = 36'(cy_s_ff);
                  b_sel = 33'(t1_ff);
                  acc_in = -mres;
               end
               3'd2: begin
                  a_sel = 36'(sy_ff);
                  b_sel = 33'(pan_a_ff);
                  cx_in = sat_c(SW'(cx_ff) + SW'(acc_ff) - SW'(mres));
               end
               3'd3: begin
                  a_sel = 36'(sy_ff);
                  b_sel = 33'(t1_ff);
                  acc_in = -mres;
               end
               3'd4: begin
                  a_sel = 36'(cy_s_ff);
                  b_sel = 33'(pan_a_ff);
                  cy_in = sat_c(SW'(cy_ff) + SW'(acc_ff) + SW'(mres));
               end
               default: begin
                  a_sel = 36'(cp_ff);
                  b_sel = 33'(pan_b_ff);
                  cz_in = sat_c(SW'(cz_ff) + SW'(mres));
                  state_in = EX_OFF;
               end
            endcase
         end
         EX_OFF: begin
            b_sel = 33'(cp_ff);
            acc_in = mres;
            ps_in = '0;
            state_in = EX_EYE;
         end
         EX_EYE: begin
            ps_in = ps_ff + 1'b1;
            case (ps_ff)
               3'd0: begin
                  a_sel = 36'(acc_ff);
                  b_sel = 33'(cy_s_ff);
                  ex_in = sat_c(SW'(cx_ff) + SW'(mres));
               end
               3'd1: begin
                  a_sel = 36'(acc_ff);
                  b_sel = 33'(sy_ff);
                  ey_in = sat_c(SW'(cy_ff) + SW'(mres));
               end
               default: begin
                  b_sel = 33'(sp_ff);
                  ez_in = sat_c(SW'(cz_ff) + SW'(mres));
                  state_in = EX_DONE;
               end
            endcase
         end
         EX_DONE: begin
            if (!ovalid_ff || rsp_ch.ready) begin
               oex_in = ex_ff;
               oey_in = ey_ff;
               oez_in = ez_ff;
               olx_in = cx_ff;
               oly_in = cy_ff;
               olz_in = cz_ff;
               ovalid_in = 1'b1;
               state_in = EX_IDLE;
            end
         end
         default: begin
            state_in = EX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
         ovalid_ff <= 1'b0;
         hdist_ff <= HOME_DISTANCE_RST;
         hyaw_ff <= '0;
         hpitch_ff <= '0;
         yaw_ff <= '0;
         pitch_ff <= '0;
         dist_ff <= HOME_DISTANCE_RST;
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         hdist_ff <= hdist_in;
         hyaw_ff <= hyaw_in;
         hpitch_ff <= hpitch_in;
         yaw_ff <= yaw_in;
         pitch_ff <= pitch_in;
         dist_ff <= dist_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
      ez_ff <= ez_in;
      oex_ff <= oex_in;
      oey_ff <= oey_in;
      oez_ff <= oez_in;
      olx_ff <= olx_in;
      oly_ff <= oly_in;
      olz_ff <= olz_in;
      cnt_ff <= cnt_in;
      ps_ff <= ps_in;
      pqx_ff <= pqx_in;
      pqy_ff <= pqy_in;
      pan_a_ff <= pan_a_in;
      pan_b_ff <= pan_b_in;
      sy_ff <= sy_in;
      cy_s_ff <= cy_s_in;
      sp_ff <= sp_in;
      cp_ff <= cp_in;
      t1_ff <= t1_in;
      acc_ff <= acc_in;
   end

   `ASSERT_IMPL(a_sc_done_wait, clock, reset, sc_rsp.done, state_ff == EX_SCY || state_ff == EX_SCP, "sine result while not waiting")
   `ASSERT_NEXT(a_pop_upd, clock, reset, pop, state_ff == EX_UPD, "popped word not taken up")
endmodule

// ===== design/orbit_camera_update.sv =====
// orbit camera update: one result word per mouse event word
// a word runs through its scroll steps, a yaw and then a pitch sine/cosine run,
// pan steps for a pan, and the eye math; both runs share one multiplier
// the back end takes a word only when idle; a two-word queue takes requests meanwhile
// synchronous reset loads the home registers' reset values and clears the center
// depends on ocu_pkg, ocu_ifc, ocu_front, ocu_sincos, ocu_exec
module orbit_camera_update #(
   parameter int ANGLE_BITS = ocu_pkg::ANGLE_BITS_DEF,
   parameter int COORD_BITS = ocu_pkg::COORD_BITS_DEF,
   parameter int MAX_SCROLL = ocu_pkg::MAX_SCROLL_DEF
) (
   input  logic clock,
   input  logic reset,
   ocu_req_if.sink req_ch,
   ocu_rsp_if.source rsp_ch,
   ocu_csr_if.sink csr_ch
);
   import ocu_pkg::*;

   cmd_type cmd;
   logic cmd_valid;
   logic pop;
   logic sc_start;
   logic [ANGLE_BITS-1:0] sc_angle;
   sc_rsp_type sc_rsp;

   ocu_front #(.MAX_SCROLL(MAX_SCROLL)) u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .pop(pop),
      .cmd(cmd),
      .cmd_valid(cmd_valid)
   );

   ocu_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
      .clock(clock),
      .reset(reset),
      .start(sc_start),
      .angle(sc_angle),
      .rsp(sc_rsp)
   );

   ocu_exec #(.ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)) u_exec (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .cmd_valid(cmd_valid),
      .pop(pop),
      .csr_ch(csr_ch),
      .rsp_ch(rsp_ch),
      .sc_start(sc_start),
      .sc_angle(sc_angle),
      .sc_rsp(sc_rsp)
   );
endmodule
